/* rtl/calendar_day_stepper_top_defines.svh */
// Assertion macros for the checker file of the calendar day stepper.
`ifndef CALENDAR_DAY_STEPPER_TOP_DEFINES_SVH
`define CALENDAR_DAY_STEPPER_TOP_DEFINES_SVH

// Implication in the same cycle, disabled while reset is high.
`define CDS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("calendar day stepper check failed");

// Implication into the next cycle, disabled while reset is high.
`define CDS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("calendar day stepper check failed");

// Implication into the next cycle that is also checked across reset.
`define CDS_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("calendar day stepper check failed");

`endif

/* rtl/cds_pkg.sv */
// Package with the shared types, codes and calendar helper functions.
`default_nettype none

package cds_pkg;

   localparam logic [1:0] CMD_HOLD    = 2'd0;
   localparam logic [1:0] CMD_FORWARD = 2'd1;
   localparam logic [1:0] CMD_BACK    = 2'd2;
   localparam logic [1:0] CMD_LOAD    = 2'd3;

   localparam logic [13:0] YEAR_MIN = 14'd1;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   // Reciprocal multipliers for division by 100 and by 7.
   localparam logic [25:0] RECIP_100 = 26'd5243;
   localparam logic [27:0] RECIP_7   = 28'd9363;

   // Reset date 1980-01-01, which is a Tuesday.
   localparam logic [6:0] RESET_CENTURY = 7'd19;
   localparam logic [6:0] RESET_YY      = 7'd80;
   localparam logic [3:0] RESET_MONTH   = 4'd1;
   localparam logic [4:0] RESET_DAY     = 5'd1;
   localparam logic [2:0] RESET_WDAY    = 3'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } in_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  century;
      logic [6:0]  yy;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] wsum;
   } prep_type;

   function automatic logic is_leap(input logic [6:0] century, input logic [6:0] yy);
      logic leap;
      if (yy == 7'd0) begin
         leap = (century[1:0] == 2'd0);
      end else begin
         leap = (yy[1:0] == 2'd0);
      end
      return leap;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   function automatic logic [2:0] month_key(input logic [3:0] month);
      logic [2:0] key;
      case (month)
         4'd1:    key = 3'd0;
         4'd2:    key = 3'd3;
         4'd3:    key = 3'd2;
         4'd4:    key = 3'd5;
         4'd5:    key = 3'd0;
         4'd6:    key = 3'd3;
         4'd7:    key = 3'd5;
         4'd8:    key = 3'd1;
         4'd9:    key = 3'd4;
         4'd10:   key = 3'd6;
         4'd11:   key = 3'd2;
         default: key = 3'd4;
      endcase
      return key;
   endfunction

   // Full year from century and year of century, by shifts and adds.
   function automatic logic [13:0] year_of(input logic [6:0] century, input logic [6:0] yy);
      logic [13:0] c;
      c = {7'd0, century};
      return (c << 6) + (c << 5) + (c << 2) + {7'd0, yy};
   endfunction

   // Quotient by 100 of a year up to 9999.
   function automatic logic [6:0] div100(input logic [13:0] y);
      logic [25:0] prod;
      prod = {12'd0, y} * RECIP_100;
      return prod[25:19];
   endfunction

endpackage

`default_nettype wire

/* rtl/cds_load_prep.sv */
// Load preparation stage: year split, day clamp and weekday sum of a loaded date.
`default_nettype none

module cds_load_prep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire cds_pkg::in_type   in_word,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output cds_pkg::prep_type      out_word
);

   logic              valid_ff;
   logic              valid_in;
   cds_pkg::prep_type word_ff;
   cds_pkg::prep_type word_in;

   logic [6:0]  century;
   logic [6:0]  yy;
   logic        leap;
   logic [4:0]  len;
   logic [4:0]  day_clamped;
   logic [13:0] year_adj;
   logic [6:0]  century_adj;

   always_comb begin
      century     = cds_pkg::div100(in_word.year);
      yy          = 7'(in_word.year - cds_pkg::year_of(century, 7'd0));
      leap        = cds_pkg::is_leap(century, yy);
      len         = cds_pkg::month_len(in_word.month, leap);
      if (in_word.day == 5'd0) begin
         day_clamped = 5'd1;
      end else if (in_word.day > len) begin
         day_clamped = len;
      end else begin
         day_clamped = in_word.day;
      end
      year_adj    = (in_word.month < 4'd3) ? in_word.year - 14'd1 : in_word.year;
      century_adj = cds_pkg::div100(year_adj);

      word_in.command = in_word.command;
      word_in.century = century;
      word_in.yy      = yy;
      word_in.month   = in_word.month;
      word_in.day     = day_clamped;
      word_in.wsum    = year_adj + {2'd0, year_adj[13:2]} - {7'd0, century_adj}
                        + {9'd0, century_adj[6:2]}
                        + {11'd0, cds_pkg::month_key(in_word.month)}
                        + {9'd0, day_clamped};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cds_date_core.sv */
// Date state, day stepping, weekday tracking and the result register.
`default_nettype none

module cds_date_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire cds_pkg::prep_type  in_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [13:0]             year_out,
   output logic [3:0]              month_out,
   output logic [4:0]              day_out,
   output logic [2:0]              weekday
);

   logic [6:0] century_ff;
   logic [6:0] century_in;
   logic [6:0] yy_ff;
   logic [6:0] yy_in;
   logic [3:0] month_ff;
   logic [3:0] month_in;
   logic [4:0] day_ff;
   logic [4:0] day_in;
   logic [2:0] wday_ff;
   logic [2:0] wday_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [13:0] year_out_ff;
   logic [3:0]  month_out_ff;
   logic [4:0]  day_out_ff;
   logic [2:0]  wday_out_ff;

   logic        fire;
   logic        leap;
   logic [4:0]  len;
   logic        at_max;
   logic        at_min;
   logic [3:0]  month_prev;
   logic [27:0] prod;
   logic [11:0] quot;
   logic [14:0] quot7;
   logic [14:0] rem;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      leap       = cds_pkg::is_leap(century_ff, yy_ff);
      len        = cds_pkg::month_len(month_ff, leap);
      at_max     = (century_ff == 7'd99) && (yy_ff == 7'd99) && (month_ff == 4'd12)
                   && (day_ff == 5'd31);
      at_min     = (century_ff == 7'd0) && (yy_ff == 7'd1) && (month_ff == 4'd1)
                   && (day_ff == 5'd1);
      month_prev = (month_ff == 4'd1) ? 4'd12 : month_ff - 4'd1;

      prod  = {14'd0, in_word.wsum} * cds_pkg::RECIP_7;
      quot  = prod[27:16];
      quot7 = {quot, 3'd0} - {3'd0, quot};
      rem   = {1'b0, in_word.wsum} - quot7;

      century_in = century_ff;
      yy_in      = yy_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      wday_in    = wday_ff;

      case (in_word.command)
         cds_pkg::CMD_FORWARD: begin
            if (!at_max) begin
               wday_in = (wday_ff == 3'd6) ? 3'd0 : wday_ff + 3'd1;
               if (day_ff < len) begin
                  day_in = day_ff + 5'd1;
               end else begin
                  day_in = 5'd1;
                  if (month_ff == 4'd12) begin
                     month_in = 4'd1;
                     if (yy_ff == 7'd99) begin
                        yy_in      = 7'd0;
                        century_in = century_ff + 7'd1;
                     end else begin
                        yy_in = yy_ff + 7'd1;
                     end
                  end else begin
                     month_in = month_ff + 4'd1;
                  end
               end
            end
         end
         cds_pkg::CMD_BACK: begin
            if (!at_min) begin
               wday_in = (wday_ff == 3'd0) ? 3'd6 : wday_ff - 3'd1;
               if (day_ff > 5'd1) begin
                  day_in = day_ff - 5'd1;
               end else begin
                  month_in = month_prev;
                  day_in   = cds_pkg::month_len(month_prev, leap);
                  if (month_ff == 4'd1) begin
                     if (yy_ff == 7'd0) begin
                        yy_in      = 7'd99;
                        century_in = century_ff - 7'd1;
                     end else begin
                        yy_in = yy_ff - 7'd1;
                     end
                  end
               end
            end
         end
         cds_pkg::CMD_LOAD: begin
            century_in = in_word.century;
            yy_in      = in_word.yy;
            month_in   = in_word.month;
            day_in     = in_word.day;
            wday_in    = rem[2:0];
         end
         default: begin
         end
      endcase

      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         century_ff   <= cds_pkg::RESET_CENTURY;
         yy_ff        <= cds_pkg::RESET_YY;
         month_ff     <= cds_pkg::RESET_MONTH;
         day_ff       <= cds_pkg::RESET_DAY;
         wday_ff      <= cds_pkg::RESET_WDAY;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            century_ff <= century_in;
            yy_ff      <= yy_in;
            month_ff   <= month_in;
            day_ff     <= day_in;
            wday_ff    <= wday_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         year_out_ff  <= cds_pkg::year_of(century_in, yy_in);
         month_out_ff <= month_in;
         day_out_ff   <= day_in;
         wday_out_ff  <= wday_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign year_out  = year_out_ff;
   assign month_out = month_out_ff;
   assign day_out   = day_out_ff;
   assign weekday   = wday_out_ff;

endmodule

`default_nettype wire

/* rtl/calendar_day_stepper_top.sv */
// An accepted input word passes the input, preparation and result registers before its result word; stalls add delay.
// Throughput: one word per cycle while the result side takes words; the date registers update on each accepted word.
// Load words pass a clamp register and a preparation register before the date stage.
// Reset is synchronous and active high; it empties the pipeline and sets 1980-01-01.
// A result word waits in the output register; earlier stages accept only until their registers are full.
`default_nettype none

module calendar_day_stepper_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // load_year, load_month, load_day, zero fill
   input  wire logic [1:0]  req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // year_out, month_out, day_out, weekday, zero fill
);

   logic              in_valid_ff;
   logic              in_valid_in;
   cds_pkg::in_type   in_word_ff;
   cds_pkg::in_type   in_word_in;
   logic              prep_ready;
   logic              prep_valid;
   cds_pkg::prep_type prep_word;
   logic              core_ready;
   logic [13:0]       year_out;
   logic [3:0]        month_out;
   logic [4:0]        day_out;
   logic [2:0]        weekday;
   logic [13:0]       req_year;
   logic [3:0]        req_month;

   assign req_year  = req_tdata[13:0];
   assign req_month = req_tdata[17:14];

   always_comb begin
      in_word_in.command = req_tuser;
      if (req_year < cds_pkg::YEAR_MIN) begin
         in_word_in.year = cds_pkg::YEAR_MIN;
      end else if (req_year > cds_pkg::YEAR_MAX) begin
         in_word_in.year = cds_pkg::YEAR_MAX;
      end else begin
         in_word_in.year = req_year;
      end
      if (req_month == 4'd0) begin
         in_word_in.month = 4'd1;
      end else if (req_month > 4'd12) begin
         in_word_in.month = 4'd12;
      end else begin
         in_word_in.month = req_month;
      end
      in_word_in.day = req_tdata[22:18];
   end

   assign req_tready  = !in_valid_ff || prep_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= in_word_in;
      end
   end

   cds_load_prep u_load_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (prep_ready),
      .in_word   (in_word_ff),
      .out_valid (prep_valid),
      .out_ready (core_ready),
      .out_word  (prep_word)
   );

   cds_date_core u_date_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (core_ready),
      .in_word   (prep_word),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .year_out  (year_out),
      .month_out (month_out),
      .day_out   (day_out),
      .weekday   (weekday)
   );

   assign rsp_tdata = {6'd0, weekday, day_out, month_out, year_out};

endmodule

`default_nettype wire

/* rtl/cds_checker.sv */
// Port checker for the calendar day stepper and its bind to the top level.
`default_nettype none
`include "calendar_day_stepper_top_defines.svh"

module cds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic date_ok;
   logic at_max_date;
   logic at_min_date;

   assign date_ok = (rsp_tdata[13:0] >= 14'd1) && (rsp_tdata[13:0] <= 14'd9999)
                    && (rsp_tdata[17:14] >= 4'd1) && (rsp_tdata[17:14] <= 4'd12)
                    && (rsp_tdata[22:18] >= 5'd1) && (rsp_tdata[25:23] <= 3'd6);
   assign at_max_date = (rsp_tdata[13:0] == 14'd9999) && (rsp_tdata[17:14] == 4'd12)
                        && (rsp_tdata[22:18] == 5'd31);
   assign at_min_date = (rsp_tdata[13:0] == 14'd1) && (rsp_tdata[17:14] == 4'd1)
                        && (rsp_tdata[22:18] == 5'd1);

   `CDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   `CDS_ASSERT_NOW(a_date_range, clock, reset, rsp_tvalid, date_ok)
   `CDS_ASSERT_NOW(a_limit_weekday, clock, reset, rsp_tvalid && (at_max_date || at_min_date),
                   (at_max_date && (rsp_tdata[25:23] == 3'd5))
                   || (at_min_date && (rsp_tdata[25:23] == 3'd1)))
   `CDS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind calendar_day_stepper_top cds_checker u_cds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* bench/calendar_day_stepper_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts each date word of the calendar day stepper and compares the results.
module calendar_day_stepper_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // load_year, load_month, load_day, zero fill
   input  logic [1:0]  req_tuser,   // command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // year_out, month_out, day_out, weekday, zero fill
   output int          fail_count,
   output int          dates_pending,
   output int          dates_checked
);

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  wday;
   } date_word_type;

   date_word_type expected_dates[$];
   int            cal_year;
   int            cal_month;
   int            cal_day;

   function automatic bit leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_days(input int m, input int y);
      case (m)
         2: begin
            return leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic int weekday_of(input int y, input int m, input int d);
      int keys[12];
      int yy;
      keys = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      yy = (m < 3) ? y - 1 : y;
      return (yy + yy / 4 - yy / 100 + yy / 400 + keys[m - 1] + d) % 7;
   endfunction

   function automatic int field_mismatch(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic apply_command(input logic [1:0] cmd, input logic [23:0] data);
      int y;
      int m;
      int d;
      case (cmd)
         cds_pkg::CMD_FORWARD: begin
            if (!(cal_year >= cds_pkg::YEAR_MAX && cal_month == 12 && cal_day >= 31)) begin
               cal_day++;
               if (cal_day > month_days(cal_month, cal_year)) begin
                  cal_day = 1;
                  cal_month++;
                  if (cal_month > 12) begin
                     cal_month = 1;
                     cal_year++;
                  end
               end
            end
         end
         cds_pkg::CMD_BACK: begin
            if (!(cal_year <= cds_pkg::YEAR_MIN && cal_month == 1 && cal_day <= 1)) begin
               if (cal_day > 1) begin
                  cal_day--;
               end else begin
                  if (cal_month > 1) begin
                     cal_month--;
                  end else begin
                     cal_month = 12;
                     cal_year--;
                  end
                  cal_day = month_days(cal_month, cal_year);
               end
            end
         end
         cds_pkg::CMD_LOAD: begin
            y = int'(data[13:0]);
            m = int'(data[17:14]);
            d = int'(data[22:18]);
            if (y < cds_pkg::YEAR_MIN) y = cds_pkg::YEAR_MIN;
            if (y > cds_pkg::YEAR_MAX) y = cds_pkg::YEAR_MAX;
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            if (d < 1) d = 1;
            if (d > month_days(m, y)) d = month_days(m, y);
            cal_year  = y;
            cal_month = m;
            cal_day   = d;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      date_word_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         cal_year  = 1980;
         cal_month = 1;
         cal_day   = 1;
         expected_dates.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata);
            want.year  = 14'(cal_year);
            want.month = 4'(cal_month);
            want.day   = 5'(cal_day);
            want.wday  = 3'(weekday_of(cal_year, cal_month, cal_day));
            expected_dates.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("result word %h arrived with no date expected", rsp_tdata);
               errs++;
            end else begin
               want = expected_dates.pop_front();
               errs += field_mismatch("year_out", int'(want.year), int'(rsp_tdata[13:0]));
               errs += field_mismatch("month_out", int'(want.month), int'(rsp_tdata[17:14]));
               errs += field_mismatch("day_out", int'(want.day), int'(rsp_tdata[22:18]));
               errs += field_mismatch("weekday", int'(want.wday), int'(rsp_tdata[25:23]));
               dates_checked <= dates_checked + 1;
            end
         end
      end
      fail_count    <= fail_count + errs;
      dates_pending <= expected_dates.size();
   end

endmodule

/* bench/calendar_day_stepper_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the calendar day stepper: clock, reset, stimulus and the final verdict.
module calendar_day_stepper_top_tb;

   localparam int RUN_LIMIT       = 400000;
   localparam int RANDOM_WORDS    = 500;
   localparam int PRESSURE_AT     = 100;
   localparam int PRESSURE_CYCLES = 200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // load_year, load_month, load_day, zero fill
   logic [1:0]  req_tuser;   // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // year_out, month_out, day_out, weekday, zero fill

   int fail_count;
   int dates_pending;
   int dates_checked;
   int cycle_count;
   int words_sent;
   int n_load;
   int n_forward;
   int n_back;
   int n_hold;
   bit pressure_done;

   calendar_day_stepper_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   calendar_day_stepper_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .dates_pending (dates_pending),
      .dates_checked (dates_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Stretches with no idling around the long hold-off and later in the run.
   function automatic int next_gap();
      int r;
      if ((words_sent >= PRESSURE_AT && words_sent < PRESSURE_AT + 70) ||
          (words_sent >= 350 && words_sent < 420)) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input logic [1:0] cmd, input int y, input int m, input int d,
                            input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, 5'(d), 4'(m), 14'(y)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      case (cmd)
         cds_pkg::CMD_LOAD: begin
            n_load++;
         end
         cds_pkg::CMD_FORWARD: begin
            n_forward++;
         end
         cds_pkg::CMD_BACK: begin
            n_back++;
         end
         default: begin
            n_hold++;
         end
      endcase
   endtask

   initial begin
      int   r;
      int   len;
      logic level;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!pressure_done && words_sent >= PRESSURE_AT) begin
            level = 1'b0;
            len = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               level = 1'b1;
               len = $urandom_range(1, 16);
            end else if (r < 70) begin
               level = 1'b1;
               len = $urandom_range(60, 120);
            end else if (r < 93) begin
               level = 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               len = $urandom_range(8, 40);
            end
         end
         @(negedge clock);
         rsp_tready <= level;
         repeat (len - 1) @(negedge clock);
      end
   end

   initial begin
      int          r;
      int          k;
      int          run_len;
      int          target;
      logic [1:0]  dir;
      logic [1:0]  cmd;
      int          y;
      int          m;
      int          d;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = cds_pkg::CMD_HOLD;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(cds_pkg::CMD_HOLD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 0, 0, 0, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 16383, 15, 31, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 10000, 13, 31, next_gap());
      send_word(cds_pkg::CMD_LOAD, 2000, 2, 31, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 1900, 2, 29, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 2023, 2, 29, next_gap());
      send_word(cds_pkg::CMD_LOAD, 2024, 2, 29, next_gap());
      send_word(cds_pkg::CMD_LOAD, 2024, 4, 31, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 1999, 12, 31, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_BACK, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_LOAD, 9999, 12, 30, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());
      send_word(cds_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, next_gap());

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 7))
               0: y = $urandom_range(1, 2);
               1: y = $urandom_range(9998, 9999);
               2: y = 100 * $urandom_range(1, 99);
               3: y = 4 * $urandom_range(1, 2499);
               default: y = $urandom_range(1, 9999);
            endcase
            if (y <= 2 && $urandom_range(0, 1)) begin
               m = 1;
            end else if (y >= 9998 && $urandom_range(0, 1)) begin
               m = 12;
            end else begin
               m = $urandom_range(1, 12);
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
               d = $urandom_range(28, 31);
            end else if (r < 75) begin
               d = $urandom_range(1, 2);
            end else begin
               d = $urandom_range(1, 31);
            end
            send_word(cds_pkg::CMD_LOAD, y, m, d, next_gap());
         end else begin
            send_word(cds_pkg::CMD_LOAD, $urandom, $urandom, $urandom, next_gap());
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
         dir = $urandom_range(0, 1) ? cds_pkg::CMD_FORWARD : cds_pkg::CMD_BACK;
         for (k = 0; k < run_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               cmd = dir;
            end else if (r < 90) begin
               cmd = (dir == cds_pkg::CMD_FORWARD) ? cds_pkg::CMD_BACK : cds_pkg::CMD_FORWARD;
            end else begin
               cmd = cds_pkg::CMD_HOLD;
            end
            send_word(cmd, $urandom, $urandom, $urandom, next_gap());
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (dates_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d words: %0d loads, %0d forward steps, %0d back steps, %0d holds.",
               words_sent, n_load, n_forward, n_back, n_hold);
      $display("Compared %0d date words; the result side was held off once for %0d cycles.",
               dates_checked, PRESSURE_CYCLES);
      if (fail_count == 0 && dates_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
